@@ hw/rtl/saep_pkg.sv @@
// ----------------------------------------------------------------------------
// saep_pkg
// Shared constants and the CORDIC arctangent table of the spherical array element position unit.
// ----------------------------------------------------------------------------
`default_nettype none
package saep_pkg;

	localparam int RotationSteps = 16;
	localparam int MaxPerAxis    = 256;

	localparam int RegRadius  = 0;
	localparam int RegAzCount = 1;
	localparam int RegElCount = 2;
	localparam int RegMinEl   = 3;
	localparam int RegMaxEl   = 4;
	localparam int CfgIdxW    = 3;

	localparam logic signed [27:0] PiQ24     = 28'sd52707179;
	localparam logic signed [27:0] HalfPiQ24 = 28'sd26353589;
	localparam logic signed [27:0] TwoPiQ24  = 28'sd105414357;
	localparam logic [15:0]        TwoPiQ13  = 16'd51472;
	localparam logic signed [19:0] CordicX0  = 20'sd39797;
	localparam logic signed [19:0] OneQ16    = 20'sd65536;
	localparam logic signed [17:0] PosMax    = 18'sd65535;

	function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
		logic signed [27:0] r;
		case (i)
			5'd0: r = 28'sd13176795;
			5'd1: r = 28'sd7778716;
			5'd2: r = 28'sd4110060;
			5'd3: r = 28'sd2086331;
			5'd4: r = 28'sd1047214;
			5'd5: r = 28'sd524117;
			5'd6: r = 28'sd262123;
			5'd7: r = 28'sd131069;
			default: r = 28'sd1 <<< (5'd24 - i);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/saep_if.sv @@
// ----------------------------------------------------------------------------
// saep_if
// Valid/ready channel interfaces: request, result and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none
interface saep_req_if;
	logic valid;
	logic ready;
	logic restart;
	modport source (output valid, output restart, input ready);
	modport sink   (input valid, input restart, output ready);
endinterface

interface saep_res_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] pos_front;
	logic signed [16:0] pos_right;
	logic signed [16:0] pos_up;
	logic [15:0]        element_index;
	logic               last_element;
	modport source (output valid, pos_front, pos_right, pos_up, element_index,
		last_element, input ready);
	modport sink   (input valid, pos_front, pos_right, pos_up, element_index,
		last_element, output ready);
endinterface

interface saep_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/sphere_array_element_positions_unit.sv @@
// ----------------------------------------------------------------------------
// sphere_array_element_positions_unit
// Spherical sensor array element position generator.
//
// Each request beat (restart bit) yields one result beat with the front,
// right and up position of the next element (1/256 m, saturated), its
// row-major index and a last-element flag. Elevation rows are the outer
// order, azimuth the inner; counters wrap after the last element.
// The config channel writes radius, azimuth count, elevation count and the
// elevation limits; write it only while the unit is idle.
// Each element runs two divisions on the shared serial divider (one when
// there is a single elevation row), two angles on the shared CORDIC, and
// then the multiplies and output.
// One element is in flight at a time; req.ready is low while it works.
// The result sits in an output register until taken; a stalled receiver
// holds req.ready low, and the next request is accepted when the result is
// taken or together with it.
// Reset loads the default registers and returns to element zero.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_array_element_positions_unit
	import saep_pkg::*;
#(
	parameter int ROTATION_STEPS = RotationSteps
) (
	input wire logic clk,
	input wire logic arst_n,
	saep_req_if.sink   req,
	saep_res_if.source res,
	saep_cfg_if.sink   cfg
);
	typedef enum logic [3:0] {
		S_IDLE, S_AZDIV, S_ELDIV, S_COS_AZ, S_COS_EL, S_MUL1, S_MUL2, S_MUL3,
		S_MUL4, S_OUT
	} state_t;

	state_t state_q;

	logic [15:0]        radius_q;
	logic [8:0]         azc_raw_q, elc_raw_q;
	logic signed [14:0] min_el_q, max_el_q;
	logic [7:0]         az_cnt_q, el_cnt_q;

	logic [8:0] azc, elc;
	assign azc = (azc_raw_q == 9'd0) ? 9'd1 :
		(azc_raw_q > 9'(MaxPerAxis)) ? 9'(MaxPerAxis) : azc_raw_q;
	assign elc = (elc_raw_q == 9'd0) ? 9'd1 :
		(elc_raw_q > 9'(MaxPerAxis)) ? 9'(MaxPerAxis) : elc_raw_q;

	assign cfg.ready = (state_q == S_IDLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q  <= 16'd256;
			azc_raw_q <= 9'd8;
			elc_raw_q <= 9'd4;
			min_el_q  <= -15'sd12868;
			max_el_q  <= 15'sd12868;
		end else if (cfg.valid && cfg.ready) begin
			case (32'(cfg.index))
				RegRadius:  radius_q  <= cfg.data;
				RegAzCount: azc_raw_q <= cfg.data[8:0];
				RegElCount: elc_raw_q <= cfg.data[8:0];
				RegMinEl:   min_el_q  <= cfg.data[14:0];
				RegMaxEl:   max_el_q  <= cfg.data[14:0];
				default: ;
			endcase
		end
	end

	// shared divider
	logic        div_start, div_done;
	logic [23:0] div_num, div_quot;
	logic [8:0]  div_den;
	saep_divider #(.NumW(24), .DenW(9)) u_div (
		.clk, .arst_n, .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quot(div_quot)
	);

	// shared CORDIC
	logic               cor_start, cor_done;
	logic signed [16:0] cor_ang;
	logic signed [17:0] cor_cos, cor_sin;
	saep_cordic #(.Steps(ROTATION_STEPS)) u_cor (
		.clk, .arst_n, .start(cor_start), .ang(cor_ang), .done(cor_done),
		.cos_o(cor_cos), .sin_o(cor_sin)
	);

	logic signed [16:0] az_ang_q, el_ang_q;
	logic signed [17:0] ca_q, sa_q;
	logic               el_neg_q;
	logic signed [16:0] el_span;
	logic [7:0]         az_c, el_c;

	// shared multiplier
	logic signed [17:0] mul_a, mul_b;
	logic signed [36:0] mul_p;
	logic signed [20:0] mul_r;
	assign mul_p = mul_a * mul_b + 37'sd32768;
	assign mul_r = 21'(mul_p >>> 16);

	logic signed [17:0] hf_q, hr_q;
	logic signed [20:0] pf_q, pr_q;
	logic signed [17:0] ce_q, se_q;
	logic               last_q;
	logic [15:0]        idx_q;

	function automatic logic signed [16:0] sat(input logic signed [20:0] v);
		if (v > 21'(PosMax)) return 17'(PosMax);
		if (v < -21'(PosMax)) return -17'(PosMax);
		return 17'(v);
	endfunction

	logic res_valid_q;
	assign res.valid = res_valid_q;
	assign req.ready = (state_q == S_IDLE) && (!res_valid_q || res.ready);

	always_comb begin
		el_span = 17'(max_el_q) - 17'(min_el_q);
		div_start = 1'b0;
		div_num   = '0;
		div_den   = azc;
		cor_start = 1'b0;
		cor_ang   = az_ang_q;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_IDLE: begin
				div_num = 24'(TwoPiQ13) * 24'(az_c);
				div_den = azc;
				div_start = req.valid && req.ready;
			end
			S_AZDIV: begin
				div_num = 24'(el_span < 0 ? -el_span : el_span) * 24'(el_cnt_q);
				div_den = elc - 9'd1;
				div_start = div_done && (elc != 9'd1);
				cor_start = div_done && (elc == 9'd1);
				cor_ang = 17'(div_quot);
			end
			S_ELDIV: cor_start = div_done;
			S_COS_AZ: begin
				cor_ang = el_ang_q;
				cor_start = cor_done;
			end
			S_MUL1: begin mul_a = ce_q; mul_b = ca_q; end
			S_MUL2: begin mul_a = ce_q; mul_b = sa_q; end
			S_MUL3: begin mul_a = 18'(radius_q); mul_b = hf_q; end
			S_MUL4: begin mul_a = 18'(radius_q); mul_b = hr_q; end
			S_OUT:  begin mul_a = 18'(radius_q); mul_b = se_q; end
			default: ;
		endcase
	end

	assign az_c = (req.restart || az_cnt_q >= azc) ? 8'd0 : az_cnt_q;
	assign el_c = (req.restart || el_cnt_q >= elc) ? 8'd0 : el_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			az_cnt_q    <= '0;
			el_cnt_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res.valid && res.ready) res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					az_cnt_q <= az_c;
					el_cnt_q <= el_c;
					el_neg_q <= el_span < 0;
					idx_q    <= 16'(17'(el_c) * 17'(azc) + 17'(az_c));
					last_q   <= ({1'b0, az_c} == azc - 9'd1) &&
						({1'b0, el_c} == elc - 9'd1);
					state_q  <= S_AZDIV;
				end
				S_AZDIV: if (div_done) begin
					az_ang_q <= 17'(div_quot);
					if (elc == 9'd1) begin
						el_ang_q <= 17'(min_el_q);
						state_q  <= S_COS_AZ;
					end else state_q <= S_ELDIV;
				end
				S_ELDIV: if (div_done) begin
					el_ang_q <= 17'(min_el_q) +
						(el_neg_q ? -17'(div_quot) : 17'(div_quot));
					state_q <= S_COS_AZ;
				end
				S_COS_AZ: if (cor_done) begin
					ca_q <= cor_cos;
					sa_q <= cor_sin;
					state_q <= S_COS_EL;
				end
				S_COS_EL: if (cor_done) begin
					ce_q <= cor_cos;
					se_q <= cor_sin;
					state_q <= S_MUL1;
				end
				S_MUL1: begin hf_q <= 18'(mul_r); state_q <= S_MUL2; end
				S_MUL2: begin hr_q <= 18'(mul_r); state_q <= S_MUL3; end
				S_MUL3: begin pf_q <= mul_r; state_q <= S_MUL4; end
				S_MUL4: begin pr_q <= mul_r; state_q <= S_OUT; end
				S_OUT: begin
					res.pos_front     <= sat(pf_q);
					res.pos_right     <= sat(pr_q);
					res.pos_up        <= sat(mul_r);
					res.element_index <= idx_q;
					res.last_element  <= last_q;
					res_valid_q       <= 1'b1;
					if ({1'b0, az_cnt_q} + 9'd1 >= azc) begin
						az_cnt_q <= '0;
						el_cnt_q <= ({1'b0, el_cnt_q} + 9'd1 >= elc) ? 8'd0 :
							el_cnt_q + 8'd1;
					end else az_cnt_q <= az_cnt_q + 8'd1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_busy_no_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready) else $error("ready while busy");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> res.valid) else $error("result dropped");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL1) |-> ({1'b0, az_cnt_q} < azc)) else $error("az range");
	a_flag_idx: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == S_OUT) else $error("bad emit");
endmodule
`default_nettype wire

@@ hw/rtl/saep_divider.sv @@
// ----------------------------------------------------------------------------
// saep_divider
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`default_nettype none
module saep_divider #(
	parameter int NumW = 24,
	parameter int DenW = 9
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire logic [NumW-1:0] num,
	input  wire logic [DenW-1:0] den,
	output logic                 done,
	output logic [NumW-1:0]      quot
);
	localparam int CntW = $clog2(NumW + 1);

	logic [NumW-1:0] num_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   diff;

	assign trial = {rem_q[DenW-1:0], num_q[NumW-1]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				num_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= CntW'(NumW);
			end else if (busy_q) begin
				if (!diff[DenW]) begin
					rem_q <= diff;
					num_q <= {num_q[NumW-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					num_q <= {num_q[NumW-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign quot = num_q;
endmodule
`default_nettype wire

@@ hw/rtl/saep_cordic.sv @@
// ----------------------------------------------------------------------------
// saep_cordic
// Iterative rotation-mode CORDIC: Q13 angle in, Q16 cos/sin out.
// ----------------------------------------------------------------------------
`default_nettype none
module saep_cordic
	import saep_pkg::*;
#(
	parameter int Steps = RotationSteps
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [16:0] ang,
	output logic                    done,
	output logic signed [17:0]      cos_o,
	output logic signed [17:0]      sin_o
);
	logic signed [27:0] z0, z1, z2;
	logic               neg0;
	logic signed [27:0] z_q;
	logic signed [19:0] x_q, y_q;
	logic               neg_q, busy_q;
	logic [4:0]         i_q;
	logic signed [19:0] xf, yf;

	always_comb begin
		z0 = 28'(ang) <<< 11;
		if (z0 >= PiQ24) z0 = z0 - TwoPiQ24;
		if (z0 < -PiQ24) z0 = z0 + TwoPiQ24;
		neg0 = 1'b0;
		z1 = z0;
		if (z0 > HalfPiQ24) begin
			z1 = z0 - PiQ24; neg0 = 1'b1;
		end else if (z0 < -HalfPiQ24) begin
			z1 = z0 + PiQ24; neg0 = 1'b1;
		end
		z2 = z1;
		xf = neg_q ? -x_q : x_q;
		yf = neg_q ? -y_q : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				z_q    <= z2;
				neg_q  <= neg0;
				x_q    <= CordicX0;
				y_q    <= '0;
				i_q    <= '0;
			end else if (busy_q) begin
				if (z_q >= 0) begin
					x_q <= x_q - (y_q >>> i_q);
					y_q <= y_q + (x_q >>> i_q);
					z_q <= z_q - atan_q24(i_q);
				end else begin
					x_q <= x_q + (y_q >>> i_q);
					y_q <= y_q - (x_q >>> i_q);
					z_q <= z_q + atan_q24(i_q);
				end
				i_q <= i_q + 1'b1;
				if (i_q == 5'(Steps - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	assign cos_o = (xf > OneQ16) ? 18'(OneQ16) : (xf < -OneQ16) ? -18'(OneQ16) : 18'(xf);
	assign sin_o = (yf > OneQ16) ? 18'(OneQ16) : (yf < -OneQ16) ? -18'(OneQ16) : 18'(yf);
endmodule
`default_nettype wire

@@ verif/sphere_array_element_positions_unit_tb.sv @@
// ----------------------------------------------------------------------------
// sphere_array_element_positions_unit_tb
// Self-checking bench for the spherical array element position unit: a table
// of directed request beats, then random beats across several register
// settings and idling phases, each result compared with an internal model.
// ----------------------------------------------------------------------------
`default_nettype none
module sphere_array_element_positions_unit_tb;
	import saep_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles   = 200;
	localparam int LongHold      = 300;

	typedef struct packed {
		logic signed [16:0] front;
		logic signed [16:0] right;
		logic signed [16:0] up;
		logic [15:0]        idx;
		logic               last;
	} position_t;

	typedef struct {
		logic      restart;
		logic      known;
		position_t pos;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	saep_req_if req ();
	saep_res_if res ();
	saep_cfg_if cfg ();

	sphere_array_element_positions_unit DUT (
		.clk(clk), .arst_n(arst_n), .req(req), .res(res), .cfg(cfg)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// model state
	logic [15:0] m_radius;
	logic [8:0]  m_az_count, m_el_count;
	logic [14:0] m_min_el, m_max_el;
	int          m_az, m_el;

	position_t pending_positions[$];
	logic      pending_known[$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	int        send_idle_pct = 0;
	int        recv_stall_pct = 0;
	int        hold_req = 0;
	int        hold_seen = 0;
	int        hold_off = 0;
	bit        failed = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clamp_to(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	function automatic longint round_q16(longint a, longint b);
		return floor_shift(a * b + 32768, 16);
	endfunction

	task automatic rotate_q13(input int ang, output longint c, output longint s);
		longint z, x, y, a, dx, dy;
		bit neg;
		z = longint'(ang) * 2048;
		x = 39797;
		y = 0;
		neg = 0;
		if (z >= PiQ24) z -= TwoPiQ24;
		if (z < -longint'(PiQ24)) z += TwoPiQ24;
		if (z > HalfPiQ24) begin
			z -= PiQ24;
			neg = 1;
		end else if (z < -longint'(HalfPiQ24)) begin
			z += PiQ24;
			neg = 1;
		end
		for (int i = 0; i < RotationSteps && i < 24; i++) begin
			case (i)
				0: a = 13176795;
				1: a = 7778716;
				2: a = 4110060;
				3: a = 2086331;
				4: a = 1047214;
				5: a = 524117;
				6: a = 262123;
				7: a = 131069;
				default: a = longint'(1) << (24 - i);
			endcase
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= a;
			end else begin
				x += dx; y -= dy; z += a;
			end
		end
		if (neg) begin
			x = -x; y = -y;
		end
		c = clamp_to(x, 65536);
		s = clamp_to(y, 65536);
	endtask

	function automatic int limit_count(logic [8:0] c);
		if (c == 0) return 1;
		if (c > MaxPerAxis) return MaxPerAxis;
		return int'(c);
	endfunction

	task automatic predict_position(input logic restart, output position_t p);
		int azc, elc, mn, mx, az_ang, el_ang;
		longint ca, sa, ce, se;
		azc = limit_count(m_az_count);
		elc = limit_count(m_el_count);
		mn = $signed(m_min_el);
		mx = $signed(m_max_el);
		if (restart) begin
			m_az = 0; m_el = 0;
		end
		if (m_az >= azc) m_az = 0;
		if (m_el >= elc) m_el = 0;
		az_ang = int'((longint'(TwoPiQ13) * m_az) / azc);
		if (elc == 1) el_ang = mn;
		else el_ang = mn + int'((longint'(mx - mn) * m_el) / (elc - 1));
		rotate_q13(az_ang, ca, sa);
		rotate_q13(el_ang, ce, se);
		p.front = 17'(clamp_to(round_q16(m_radius, round_q16(ce, ca)), 65535));
		p.right = 17'(clamp_to(round_q16(m_radius, round_q16(ce, sa)), 65535));
		p.up    = 17'(clamp_to(round_q16(m_radius, se), 65535));
		p.idx   = 16'(m_el * azc + m_az);
		p.last  = (m_az == azc - 1) && (m_el == elc - 1);
		m_az++;
		if (m_az >= azc) begin
			m_az = 0;
			m_el++;
			if (m_el >= elc) m_el = 0;
		end
	endtask

	task automatic write_register(input int index, input logic [15:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= index[2:0];
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
		case (index)
			RegRadius:  m_radius   = value;
			RegAzCount: m_az_count = value[8:0];
			RegElCount: m_el_count = value[8:0];
			RegMinEl:   m_min_el   = value[14:0];
			RegMaxEl:   m_max_el   = value[14:0];
			default: ;
		endcase
	endtask

	task automatic send_request(input logic restart, input logic known, input position_t pos);
		position_t p;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid   <= 1'b1;
		req.restart <= restart;
		do @(posedge clk); while (!req.ready);
		predict_position(restart, p);
		pending_positions.push_back(known ? pos : p);
		pending_known.push_back(known);
		if (known && p != pos) begin
			// directed row disagrees with the model; table value governs
		end
	endtask

	task automatic drain_results();
		req.valid <= 1'b0;
		while (pending_positions.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (hold_req != hold_seen) begin
				res.ready <= 1'b0;
				hold_seen <= hold_req;
				hold_off  <= LongHold - 1;
			end else if (hold_off > 0) begin
				res.ready <= 1'b0;
				hold_off <= hold_off - 1;
			end else begin
				res.ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// result check
	always @(posedge clk) begin
		position_t want, got;
		if (arst_n && res.valid && res.ready) begin
			got = '{res.pos_front, res.pos_right, res.pos_up, res.element_index,
				res.last_element};
			if (pending_positions.size() == 0) begin
				failed = 1;
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = pending_positions.pop_front();
				void'(pending_known.pop_front());
				if (got !== want) begin
					failed = 1;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	stim_row_t directed[$];

	task automatic random_phase(input int n, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		for (int i = 0; i < n; i++)
			send_request(($urandom_range(15) == 0), 1'b0, '0);
		drain_results();
	endtask

	task automatic random_settings(input int az_hi, input int el_hi);
		write_register(RegRadius, 16'($urandom_range(65535)));
		write_register(RegAzCount, 16'($urandom_range(az_hi)));
		write_register(RegElCount, 16'($urandom_range(el_hi)));
		write_register(RegMinEl, 16'($signed($urandom_range(25736)) - 12868));
		write_register(RegMaxEl, 16'($signed($urandom_range(25736)) - 12868));
	endtask

	initial begin
		req.valid = 1'b0;
		req.restart = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		m_radius = 16'd256;
		m_az_count = 9'd8;
		m_el_count = 9'd4;
		m_min_el = 15'h4DBC;
		m_max_el = 15'd12868;
		m_az = 0;
		m_el = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// after reset: element zero, el=-pi/2-ish -> up near -radius
		directed.push_back('{1'b0, 1'b0, '0});
		directed.push_back('{1'b1, 1'b0, '0});
		for (int i = 0; i < 32; i++) directed.push_back('{1'b0, 1'b0, '0});
		foreach (directed[i]) send_request(directed[i].restart, directed[i].known,
			directed[i].pos);
		drain_results();

		// extremes: max radius, single row and single column, zero count
		write_register(RegRadius, 16'hFFFF);
		write_register(RegAzCount, 16'd1);
		write_register(RegElCount, 16'd1);
		write_register(RegMinEl, 16'd12868);
		write_register(RegMaxEl, 16'hCDBC);
		for (int i = 0; i < 3; i++) send_request(i[0], 1'b0, '0);
		drain_results();
		write_register(RegAzCount, 16'd0);
		write_register(RegElCount, 16'd0);
		write_register(RegMinEl, 16'h4000);
		for (int i = 0; i < 2; i++) send_request(1'b0, 1'b0, '0);
		drain_results();
		write_register(RegAzCount, 16'd511);
		write_register(RegElCount, 16'd257);
		write_register(RegRadius, 16'd0);
		write_register(5, 16'h1234);
		write_register(7, 16'hFFFF);
		for (int i = 0; i < 4; i++) send_request(1'b0, 1'b0, '0);
		drain_results();
		// shrink counts mid-sequence so counters exceed them
		write_register(RegAzCount, 16'd3);
		write_register(RegElCount, 16'd2);
		write_register(RegRadius, 16'd40000);
		for (int i = 0; i < 8; i++) send_request(1'b0, 1'b0, '0);
		drain_results();

		// long receiver hold-off while requests keep coming
		hold_req++;
		for (int i = 0; i < 5; i++) send_request(1'b0, 1'b0, '0);
		drain_results();

		random_settings(12, 6);
		random_phase(300, 0, 0);
		random_settings(20, 8);
		random_phase(300, 61, 0);
		random_settings(511, 511);
		random_phase(300, 0, 61);
		random_settings(9, 9);
		random_phase(300, 17, 17);
		random_settings(511, 4);
		random_phase(300, 0, 0);
		random_settings(6, 3);
		random_phase(200, 61, 61);

		if (!failed && pending_positions.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
`default_nettype wire
